>>> hw/rtl/sliding_window_throughput_meter_defines.svh
// Assertion macros for the sliding window throughput meter checker.
// Depends on clk and rst being visible in the scope that uses them.
`ifndef SLIDING_WINDOW_THROUGHPUT_METER_DEFINES_SVH
`define SLIDING_WINDOW_THROUGHPUT_METER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define SWTM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swtm assertion failed");

// Next-cycle implication, held off during reset.
`define SWTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swtm assertion failed");

`endif

>>> hw/rtl/swtm_pkg.sv
// Shared constants and types for the sliding window throughput meter.
// No dependencies; used by the top level and its checker.
`default_nettype none

package swtm_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = QPTR_W + 1;
  localparam int DATA_W      = 32;
  localparam int WIN_W       = 16;
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [WIN_W-1:0] MAXDELTAT = WIN_W'(1000);

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_ADD   = 2'd0;
  localparam cmd_t CMD_START = 2'd1;
  localparam cmd_t CMD_STOP  = 2'd2;
  localparam cmd_t CMD_QUERY = 2'd3;

endpackage

`default_nettype wire

>>> hw/rtl/sliding_window_throughput_meter.sv
// Sliding window throughput meter: sequencer, sample queue and shared divider.
// Depends on swtm_pkg and swtm_ram.
//
// Usage
//   Input channel (in_valid/in_stall) carries cmd, now_ms and byte_count. A
//   transaction is taken when in_valid is high and in_stall is low. in_stall
//   is high while one transaction is being worked on.
//   Output channel (out_valid/out_stall) carries window_speed, average_speed
//   and is_running; exactly one result per input transaction, in order.
//   window_ms is written through cfg_we/cfg_wdata; the user must write it
//   only while the block is idle, which the block itself does not enforce.
//   Both quotients come from one restoring divider that retires one quotient
//   bit per cycle, and each eviction of a sample costs one queue memory read
//   and one compare. Items are handled one at a time; the next is taken the
//   cycle after a result is registered. A waiting result sits in the output
//   register, so the next transaction can be taken while the receiver stalls;
//   a finished second result then waits until the output register frees up.
//   Reset (rst, synchronous) empties the queue, clears the totals and times,
//   stops the meter and sets window_ms to 1000.
`default_nettype none

module sliding_window_throughput_meter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  cmd,
  input  wire logic [31:0]                 now_ms,
  input  wire logic [31:0]                 byte_count,
  input  wire logic                        cfg_we,
  input  wire logic [15:0]                 cfg_wdata,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [31:0]                      window_speed,
  output logic [31:0]                      average_speed,
  output logic                             is_running
);

  localparam int D  = swtm_pkg::QUEUE_DEPTH;
  localparam int PW = swtm_pkg::QPTR_W;
  localparam int FW = swtm_pkg::FILL_W;
  localparam int DW = swtm_pkg::DATA_W;
  localparam int CW = swtm_pkg::DIV_CNT_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CMD      = 4'd1;
  localparam logic [3:0] S_EV_RD    = 4'd2;
  localparam logic [3:0] S_EV_CMP   = 4'd3;
  localparam logic [3:0] S_PUSH     = 4'd4;
  localparam logic [3:0] S_WIN      = 4'd5;
  localparam logic [3:0] S_RD_FIRST = 4'd6;
  localparam logic [3:0] S_RD_LAST  = 4'd7;
  localparam logic [3:0] S_SPAN     = 4'd8;
  localparam logic [3:0] S_DIV      = 4'd9;
  localparam logic [3:0] S_AVG      = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  localparam logic [PW-1:0] HEAD_LAST = PW'(D - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(D);
  localparam logic [CW-1:0] DIV_LAST  = CW'(DW - 1);

  logic [3:0]              state;
  swtm_pkg::cmd_t          cmd_q;
  logic [DW-1:0]           now_q;
  logic [DW-1:0]           bytes_q;
  logic [swtm_pkg::WIN_W-1:0] window_ms;
  logic [PW-1:0]           head;
  logic [FW-1:0]           fill;
  logic                    running;
  logic [DW-1:0]           byte_total;
  logic [DW-1:0]           begin_time;
  logic [DW-1:0]           finish_time;
  logic                    post_push;
  logic [DW-1:0]           first_time;
  logic [DW-1:0]           first_total;
  logic [DW-1:0]           win_q;
  logic [DW-1:0]           avg_q;
  logic                    div_sel;
  logic [CW-1:0]           div_cnt;
  logic [DW-1:0]           div_q;
  logic [DW-1:0]           div_rem;
  logic [DW-1:0]           div_d;

  logic [PW-1:0]           raddr;
  logic                    we;
  logic [PW-1:0]           waddr;
  logic [DW-1:0]           total_next;
  logic [DW-1:0]           t_rdata;
  logic [DW-1:0]           s_rdata;
  logic [PW-1:0]           head_inc;
  logic [PW-1:0]           last_slot;
  logic [DW-1:0]           age;
  logic [DW-1:0]           span;
  logic [DW-1:0]           elapsed;
  logic [DW:0]             div_shift;
  logic [DW:0]             div_diff;
  logic                    div_bit;
  logic [DW-1:0]           div_q_next;
  logic [DW-1:0]           div_rem_next;
  logic                    out_free;

  function automatic logic [PW-1:0] slot_wrap(input logic [PW:0] s);
    logic [PW:0] r;
    r = (s >= (PW+1)'(D)) ? s - (PW+1)'(D) : s;
    return r[PW-1:0];
  endfunction

  swtm_ram #(.WIDTH(DW), .DEPTH(D)) u_times (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (now_q),
    .raddr (raddr),
    .rdata (t_rdata)
  );

  swtm_ram #(.WIDTH(DW), .DEPTH(D)) u_totals (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (total_next),
    .raddr (raddr),
    .rdata (s_rdata)
  );

  assign in_stall   = (state != S_IDLE);
  assign head_inc   = (head == HEAD_LAST) ? '0 : head + 1'b1;
  assign last_slot  = slot_wrap({1'b0, head} + (fill - 1'b1));
  assign raddr      = (state == S_RD_LAST) ? last_slot : head;
  assign we         = (state == S_PUSH);
  assign waddr      = (fill == FILL_FULL) ? head : slot_wrap({1'b0, head} + fill);
  assign total_next = byte_total + bytes_q;
  assign age        = now_q - t_rdata;
  assign span       = t_rdata - first_time;
  assign elapsed    = (running ? now_q : finish_time) - begin_time;
  assign out_free   = !out_valid || !out_stall;

  // one restoring division step per cycle
  always_comb begin
    div_shift    = {div_rem, div_q[DW-1]};
    div_diff     = div_shift - {1'b0, div_d};
    div_bit      = (div_shift >= {1'b0, div_d});
    div_rem_next = div_bit ? div_diff[DW-1:0] : div_shift[DW-1:0];
    div_q_next   = {div_q[DW-2:0], div_bit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window_ms   <= swtm_pkg::MAXDELTAT;
      head        <= '0;
      fill        <= '0;
      running     <= 1'b0;
      byte_total  <= '0;
      begin_time  <= '0;
      finish_time <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_ms <= cfg_wdata;
      end
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q   <= cmd;
            now_q   <= now_ms;
            bytes_q <= byte_count;
            state   <= S_CMD;
          end
        end
        S_CMD: begin
          unique case (cmd_q)
            swtm_pkg::CMD_ADD: begin
              post_push <= 1'b0;
              state     <= S_EV_RD;
            end
            swtm_pkg::CMD_START: begin
              running    <= 1'b1;
              byte_total <= '0;
              begin_time <= now_q;
              state      <= S_WIN;
            end
            swtm_pkg::CMD_STOP: begin
              finish_time <= now_q;
              running     <= 1'b0;
              state       <= S_WIN;
            end
            swtm_pkg::CMD_QUERY: begin
              state <= S_WIN;
            end
            default: begin
              state <= S_WIN;
            end
          endcase
        end
        S_EV_RD: begin
          if (fill != '0) begin
            state <= S_EV_CMP;
          end else if (!post_push) begin
            state <= S_PUSH;
          end else begin
            win_q <= '0;
            state <= S_AVG;
          end
        end
        S_EV_CMP: begin
          if (age > {16'b0, window_ms}) begin
            head  <= head_inc;
            fill  <= fill - 1'b1;
            state <= S_EV_RD;
          end else if (!post_push) begin
            state <= S_PUSH;
          end else if (fill < FW'(2)) begin
            win_q <= '0;
            state <= S_AVG;
          end else begin
            state <= S_RD_FIRST;
          end
        end
        S_PUSH: begin
          byte_total <= total_next;
          if (fill == FILL_FULL) begin
            head <= head_inc;
          end else begin
            fill <= fill + 1'b1;
          end
          state <= S_WIN;
        end
        S_WIN: begin
          if (!running) begin
            win_q <= '0;
            state <= S_AVG;
          end else begin
            post_push <= 1'b1;
            state     <= S_EV_RD;
          end
        end
        S_RD_FIRST: begin
          state <= S_RD_LAST;
        end
        S_RD_LAST: begin
          first_time  <= t_rdata;
          first_total <= s_rdata;
          state       <= S_SPAN;
        end
        S_SPAN: begin
          if (span == '0) begin
            win_q <= '0;
            state <= S_AVG;
          end else begin
            div_q   <= s_rdata - first_total;
            div_d   <= span;
            div_rem <= '0;
            div_cnt <= '0;
            div_sel <= 1'b0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          div_q   <= div_q_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_LAST) begin
            if (!div_sel) begin
              win_q <= div_q_next;
              state <= S_AVG;
            end else begin
              avg_q <= div_q_next;
              state <= S_DONE;
            end
          end
        end
        S_AVG: begin
          if (elapsed == '0) begin
            avg_q <= '0;
            state <= S_DONE;
          end else begin
            div_q   <= byte_total;
            div_d   <= elapsed;
            div_rem <= '0;
            div_cnt <= '0;
            div_sel <= 1'b1;
            state   <= S_DIV;
          end
        end
        S_DONE: begin
          // hold the result until the output register frees
          if (out_free) begin
            window_speed  <= win_q;
            average_speed <= avg_q;
            is_running    <= running;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/swtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module swtm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/swtm_checker.sv
// Port-level checker for the sliding window throughput meter, bound to the top.
// Depends on swtm_pkg and sliding_window_throughput_meter_defines.svh.
`default_nettype none
`include "sliding_window_throughput_meter_defines.svh"

module swtm_port_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  cmd,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] window_speed,
  input wire logic [31:0] average_speed,
  input wire logic        is_running
);

  logic in_take;
  logic stop_take;

  assign in_take   = in_valid && !in_stall;
  assign stop_take = in_take && (cmd == swtm_pkg::CMD_STOP);

  `SWTM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `SWTM_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
    $stable(window_speed) && $stable(average_speed) && $stable(is_running))
  `SWTM_ASSERT_NEXT(a_busy_after_take, in_take, in_stall)
  `SWTM_ASSERT_NOW(a_stopped_zero_window, out_valid && !is_running, window_speed == 32'd0)
  `SWTM_ASSERT_NEXT(a_stop_busy, stop_take, in_stall)

endmodule

bind sliding_window_throughput_meter swtm_port_checker u_swtm_checker (.*);

`default_nettype wire

>>> bench/swtm_checker.sv
`timescale 1ns / 100ps
// Checker for the sliding window throughput meter: predicts one speed result per
// accepted input transaction and compares it with each output transaction.
// Depends on swtm_pkg; instantiated beside the block by tb_top.
module swtm_checker
  import swtm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  cmd_t              cmd,
  input  logic [31:0]       now_ms,
  input  logic [31:0]       byte_count,
  input  logic              cfg_we,
  input  logic [WIN_W-1:0]  cfg_wdata,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [31:0]       window_speed,
  input  logic [31:0]       average_speed,
  input  logic              is_running,
  output int                err_count,
  output int                outstanding
);

  typedef struct packed {
    logic [31:0] window_speed;
    logic [31:0] average_speed;
    logic        is_running;
  } speed_rec_t;

  logic [31:0]       smp_time  [QUEUE_DEPTH];
  logic [31:0]       smp_total [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head;
  logic [FILL_W-1:0] fill;
  logic              running;
  logic [31:0]       total;
  logic [31:0]       t_begin;
  logic [31:0]       t_finish;
  logic [WIN_W-1:0]  win;
  speed_rec_t        speed_q [$];
  int                n_err = 0;

  task automatic evict_stale(input logic [31:0] now);
    while (fill != 0 && (now - smp_time[head]) > 32'(win)) begin
      head = head + 1'b1;
      fill = fill - 1'b1;
    end
  endtask

  task automatic push_sample(input logic [31:0] now);
    logic [QPTR_W-1:0] slot;
    if (fill >= FILL_W'(QUEUE_DEPTH)) begin
      head = head + 1'b1;
      fill = FILL_W'(QUEUE_DEPTH - 1);
    end
    slot = head + QPTR_W'(fill);
    smp_time[slot]  = now;
    smp_total[slot] = total;
    fill = fill + 1'b1;
  endtask

  task automatic predict_speeds(input cmd_t c, input logic [31:0] now,
                                input logic [31:0] bytes, output speed_rec_t r);
    logic [QPTR_W-1:0] last;
    logic [31:0]       span;
    logic [31:0]       t_end;
    logic [31:0]       elapsed;
    case (c)
      CMD_ADD: begin
        evict_stale(now);
        total = total + bytes;
        push_sample(now);
      end
      CMD_START: begin
        running = 1'b1;
        total   = '0;
        t_begin = now;
      end
      CMD_STOP: begin
        t_finish = now;
        running  = 1'b0;
      end
      default: ;
    endcase
    r.window_speed = '0;
    if (running) begin
      evict_stale(now);
      if (fill >= 2) begin
        last = head + QPTR_W'(fill - 1'b1);
        span = smp_time[last] - smp_time[head];
        if (span != 0)
          r.window_speed = (smp_total[last] - smp_total[head]) / span;
      end
    end
    t_end   = running ? now : t_finish;
    elapsed = t_end - t_begin;
    r.average_speed = (elapsed == 0) ? 32'd0 : total / elapsed;
    r.is_running    = running;
  endtask

  always @(posedge clk) begin
    speed_rec_t want;
    if (rst) begin
      head     = '0;
      fill     = '0;
      running  = 1'b0;
      total    = '0;
      t_begin  = '0;
      t_finish = '0;
      win      = MAXDELTAT;
      speed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (speed_q.size() == 0) begin
          $error("output transaction with no input transaction pending");
          n_err++;
        end else begin
          want = speed_q.pop_front();
          if (window_speed !== want.window_speed) begin
            $error("window_speed expected %0d actual %0d", want.window_speed, window_speed);
            n_err++;
          end
          if (average_speed !== want.average_speed) begin
            $error("average_speed expected %0d actual %0d", want.average_speed,
                   average_speed);
            n_err++;
          end
          if (is_running !== want.is_running) begin
            $error("is_running expected %0d actual %0d", want.is_running, is_running);
            n_err++;
          end
        end
      end
      if (cfg_we)
        win = cfg_wdata;
      if (in_valid && !in_stall) begin
        predict_speeds(cmd, now_ms, byte_count, want);
        speed_q.push_back(want);
      end
    end
    err_count   <= n_err;
    outstanding <= speed_q.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the sliding window throughput meter testbench: clock, reset, stimulus
// and verdict. Depends on swtm_pkg, sliding_window_throughput_meter, swtm_checker.
module tb_top;
  import swtm_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int HOLD_CYCLES  = 800;
  localparam int SETTLE_CYCLES = 400;
  localparam int PHASE_ITEMS  = 250;
  localparam int NUM_PHASES   = 8;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  cmd_t             cmd;
  logic [31:0]      now_ms;
  logic [31:0]      byte_count;
  logic             cfg_we;
  logic [WIN_W-1:0] cfg_wdata;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [31:0]      window_speed;
  logic [31:0]      average_speed;
  logic             is_running;

  int               err_count;
  int               outstanding;
  int               cycle_count = 0;
  logic             quiet = 1'b0;
  int               hold_req = 0;
  int               hold_served = 0;
  int               hold_left = 0;
  logic [31:0]      stamp;
  logic             meter_on;
  logic [WIN_W-1:0] cur_win = MAXDELTAT;

  sliding_window_throughput_meter i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .now_ms        (now_ms),
    .byte_count    (byte_count),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .window_speed  (window_speed),
    .average_speed (average_speed),
    .is_running    (is_running)
  );

  swtm_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .now_ms        (now_ms),
    .byte_count    (byte_count),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .window_speed  (window_speed),
    .average_speed (average_speed),
    .is_running    (is_running),
    .err_count     (err_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_served) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 17);
    end
  end

  // returns at the edge where the transaction is taken, valid still high
  task automatic send_item(input cmd_t c, input logic [31:0] t, input logic [31:0] b);
    while (!quiet && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    now_ms     <= t;
    byte_count <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] w);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_win = w;
  endtask

  task automatic random_item();
    int          pick;
    int          w;
    logic [31:0] step;
    logic [31:0] b;
    cmd_t        c;
    w    = cur_win;
    pick = $urandom_range(0, 99);
    if (pick < 25)      step = 0;
    else if (pick < 70) step = $urandom_range(1, w / 100 + 1);
    else if (pick < 90) step = $urandom_range(1, w / 4 + 1);
    else if (pick < 98) step = $urandom_range(w / 2, 2 * w + 1);
    else                step = $urandom;
    stamp = stamp + step;
    pick = $urandom_range(0, 99);
    if (meter_on)
      c = (pick < 3) ? CMD_STOP : (pick < 5) ? CMD_START : (pick < 17) ? CMD_QUERY : CMD_ADD;
    else
      c = (pick < 25) ? CMD_START : (pick < 30) ? CMD_STOP : (pick < 40) ? CMD_QUERY : CMD_ADD;
    if (c == CMD_START)
      meter_on = 1'b1;
    else if (c == CMD_STOP)
      meter_on = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 70)      b = $urandom_range(0, 5000);
    else if (pick < 90) b = $urandom;
    else if (pick < 95) b = 32'd0;
    else                b = 32'hFFFF_FFFF;
    send_item(c, stamp, b);
  endtask

  initial begin
    int               k;
    int               ph;
    logic [WIN_W-1:0] w;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    cmd        <= CMD_QUERY;
    now_ms     <= '0;
    byte_count <= '0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // stopped meter, add while stopped, zero elapsed
    send_item(CMD_QUERY, 32'd0, 32'd0);
    send_item(CMD_ADD,   32'd0, 32'd0);
    send_item(CMD_ADD,   32'd0, 32'hFFFF_FFFF);
    send_item(CMD_STOP,  32'd5, 32'd0);
    send_item(CMD_QUERY, 32'd5, 32'd0);
    // start keeps old samples
    send_item(CMD_START, 32'd10, 32'd0);
    send_item(CMD_ADD,   32'd10, 32'd100);
    send_item(CMD_ADD,   32'd10, 32'd50);
    // eviction down to one sample, then zero span
    send_item(CMD_ADD,   32'd2000, 32'd1000);
    send_item(CMD_ADD,   32'd2000, 32'd7);
    send_item(CMD_ADD,   32'd2500, 32'hFFFF_FFFF);
    send_item(CMD_QUERY, 32'd2600, 32'd0);
    send_item(CMD_QUERY, 32'd3601, 32'hFFFF_FFFF);
    // time wraps
    send_item(CMD_ADD,   32'hFFFF_FFFF, 32'd1);
    send_item(CMD_ADD,   32'd0, 32'd2);
    send_item(CMD_ADD,   32'd3, 32'd9);
    send_item(CMD_STOP,  32'd4, 32'd0);
    send_item(CMD_QUERY, 32'd100, 32'd0);
    send_item(CMD_START, 32'd100, 32'd0);
    send_item(CMD_QUERY, 32'd100, 32'd0);
    send_item(CMD_ADD,   32'd100, 32'd0);
    send_item(CMD_STOP,  32'd100, 32'd0);
    stamp = 32'd100;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       w = 16'd1;
        1:       w = 16'hFFFF;
        2:       w = 16'd20;
        3:       w = 16'd300;
        5:       w = 16'd3;
        6:       w = 16'd5000;
        default: w = WIN_W'($urandom_range(1, 65535));
      endcase
      set_window(w);
      if (ph == 2)
        hold_req <= hold_req + 1;
      if (ph == 6)
        quiet <= 1'b1;
      stamp = stamp + $urandom_range(0, 1000);
      meter_on = 1'b1;
      send_item(CMD_START, stamp, $urandom);
      for (k = 0; k < PHASE_ITEMS; k++)
        random_item();
      if (ph == 6)
        quiet <= 1'b0;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
